/* hw/rtl/rsmmt_pkg.sv */
package rsmmt_pkg;

  localparam int ELEMENTS_DEF = 1024;

  localparam int VAL_W     = 16;
  localparam int POS_FW    = 11;
  localparam int SUM_OUT_W = 26;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 64;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

endpackage

/* hw/rtl/range_sum_min_max_tree_top.sv */
// channel | dir | tdata (low bit up)                                              | tuser
// in_     | in  | position[10:0] last_position[21:11] value[37:22], pad to 40     | kind
// out_    | out | range_sum[25:0] range_min[41:26] range_max[57:42], pad to 64   | error
//
// One request at a time: an update walks down to its leaf and back up to the root, a
// query walks its range's edges over at most D levels, D being the tree depth
// (at most ceil(log2(ELEMENTS))+1); a rejected request goes straight to the result.
// Walks go one tree level a cycle over the node memory (one write, two read ports).
// After reset the node memory is cleared, one entry a cycle, over all 4*ELEMENTS entries.
// A result waits in the output register; a stalled output holds the next request off.
module range_sum_min_max_tree_top #(
  parameter int ELEMENTS = rsmmt_pkg::ELEMENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rsmmt_pkg::IN_DATA_W-1:0]  in_tdata,   // position, last_position, value
  input  logic                             in_tuser,   // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rsmmt_pkg::OUT_DATA_W-1:0] out_tdata,  // range_sum, range_min, range_max
  output logic                             out_tuser   // error
);
  import rsmmt_pkg::*;

  localparam int DEPTH   = 4 * ELEMENTS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int POS_W   = $clog2(ELEMENTS + 1);
  localparam int SUM_W   = VAL_W + $clog2(ELEMENTS);
  localparam int ENTRY_W = SUM_W + 2 * VAL_W;
  localparam int PAD_W   = OUT_DATA_W - SUM_OUT_W - 2 * VAL_W;
  localparam logic [31:0] ELEM32 = 32'(ELEMENTS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_UP    = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [POS_W-1:0]  l;
    logic [POS_W-1:0]  r;
    logic [ADDR_W-1:0] p;
  } node_ref_t;

  typedef struct packed {
    logic      cov;
    logic      go_l;
    logic      go_r;
    node_ref_t lch;
    node_ref_t rch;
  } step_t;

  function automatic step_t walk_step(node_ref_t n, logic [POS_W-1:0] lo,
                                      logic [POS_W-1:0] hi);
    step_t            s;
    logic [POS_W:0]   lr;
    logic [POS_W-1:0] m;
    lr      = {1'b0, n.l} + {1'b0, n.r};
    m       = lr[POS_W:1];
    s.cov   = (lo <= n.l) && (n.r <= hi);
    s.go_l  = (hi <= m);
    s.go_r  = (lo > m);
    s.lch.l = n.l;
    s.lch.r = m;
    s.lch.p = {n.p[ADDR_W-2:0], 1'b0};
    s.rch.l = m + POS_W'(1);
    s.rch.r = n.r;
    s.rch.p = {n.p[ADDR_W-2:0], 1'b1};
    return s;
  endfunction

  function automatic logic signed [VAL_W-1:0] smin(logic signed [VAL_W-1:0] a,
                                                   logic signed [VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [VAL_W-1:0] smax(logic signed [VAL_W-1:0] a,
                                                   logic signed [VAL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // node memory: {max, min, sum}
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic               we;
  logic [ADDR_W-1:0]  wa, ra, rb;
  logic [ENTRY_W-1:0] wd;
  logic               re_a, re_b;
  logic [ENTRY_W-1:0] rdata_a_r, rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re_a) begin
      rdata_a_r <= mem[ra];
    end
    if (re_b) begin
      rdata_b_r <= mem[rb];
    end
  end

  logic [2:0]               state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic                     kind_r, kind_nxt;
  logic                     err_r, err_nxt;
  logic                     wl_act_r, wl_act_nxt;
  logic                     wr_act_r, wr_act_nxt;
  logic                     split_r, split_nxt;
  logic                     rv_a_r, rv_a_nxt;
  logic                     rv_b_r, rv_b_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [POS_W-1:0]         lo_r, lo_nxt, hi_r, hi_nxt;
  node_ref_t                wl_r, wl_nxt, wr_r, wr_nxt;
  logic [ADDR_W-1:0]        up_p_r, up_p_nxt;
  logic signed [SUM_W-1:0]  acc_sum_r, acc_sum_nxt;
  logic signed [VAL_W-1:0]  acc_min_r, acc_min_nxt;
  logic signed [VAL_W-1:0]  acc_max_r, acc_max_nxt;
  logic signed [VAL_W-1:0]  val_r, val_nxt;
  logic signed [SUM_OUT_W-1:0] out_sum_r;
  logic signed [VAL_W-1:0]  out_min_r, out_max_r;
  logic                     out_err_r;
  logic                     out_load;

  step_t                    step_l, step_r;
  logic signed [SUM_W-1:0]  a_sum, b_sum, add_a, add_b;
  logic signed [VAL_W-1:0]  a_min, a_max, b_min, b_max, min1, max1;
  logic [31:0]              first32, last32, lo32, hi32;
  logic signed [VAL_W-1:0]  in_val;
  logic [ADDR_W-1:0]        par;
  logic [ADDR_W-1:0]        root_addr;

  assign root_addr = ADDR_W'(1);
  assign a_sum = $signed(rdata_a_r[SUM_W-1:0]);
  assign a_min = $signed(rdata_a_r[SUM_W +: VAL_W]);
  assign a_max = $signed(rdata_a_r[SUM_W+VAL_W +: VAL_W]);
  assign b_sum = $signed(rdata_b_r[SUM_W-1:0]);
  assign b_min = $signed(rdata_b_r[SUM_W +: VAL_W]);
  assign b_max = $signed(rdata_b_r[SUM_W+VAL_W +: VAL_W]);

  assign first32 = 32'(in_tdata[POS_FW-1:0]);
  assign last32  = 32'(in_tdata[2*POS_FW-1:POS_FW]);
  assign in_val  = $signed(in_tdata[2*POS_FW +: VAL_W]);
  assign lo32    = (first32 == 32'd0) ? 32'd1 : first32;
  assign hi32    = (last32 > ELEM32) ? ELEM32 : last32;

  assign step_l = walk_step(wl_r, lo_r, hi_r);
  assign step_r = walk_step(wr_r, lo_r, hi_r);
  assign par    = {1'b0, up_p_r[ADDR_W-1:1]};

  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_FIN) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    kind_nxt    = kind_r;
    err_nxt     = err_r;
    wl_act_nxt  = wl_act_r;
    wr_act_nxt  = wr_act_r;
    split_nxt   = split_r;
    rv_a_nxt    = 1'b0;
    rv_b_nxt    = 1'b0;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    wl_nxt      = wl_r;
    wr_nxt      = wr_r;
    up_p_nxt    = up_p_r;
    acc_sum_nxt = acc_sum_r;
    acc_min_nxt = acc_min_r;
    acc_max_nxt = acc_max_r;
    val_nxt     = val_r;
    we          = 1'b0;
    wa          = '0;
    wd          = '0;
    re_a        = 1'b0;
    ra          = '0;
    re_b        = 1'b0;
    rb          = '0;
    add_a       = rv_a_r ? a_sum : '0;
    add_b       = rv_b_r ? b_sum : '0;
    min1        = rv_a_r ? smin(acc_min_r, a_min) : acc_min_r;
    max1        = rv_a_r ? smax(acc_max_r, a_max) : acc_max_r;

    unique case (state_r)
      ST_CLEAR: begin
        we          = 1'b1;
        wa          = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt    = in_tuser;
          val_nxt     = in_val;
          wl_nxt      = '{l: POS_W'(1), r: POS_W'(ELEMENTS), p: root_addr};
          wl_act_nxt  = 1'b1;
          wr_act_nxt  = 1'b0;
          split_nxt   = 1'b0;
          acc_sum_nxt = '0;
          acc_min_nxt = VAL_MAX;
          acc_max_nxt = VAL_MIN;
          if (in_tuser == KIND_QUERY) begin
            err_nxt = (first32 > last32) || (lo32 > hi32);
            lo_nxt  = POS_W'(lo32);
            hi_nxt  = POS_W'(hi32);
          end else begin
            err_nxt = (first32 == 32'd0) || (first32 > ELEM32);
            lo_nxt  = POS_W'(first32);
            hi_nxt  = POS_W'(first32);
          end
          state_nxt = err_nxt ? ST_FIN : ST_WALK;
        end
      end
      ST_WALK: begin
        if (kind_r == KIND_UPDATE) begin
          if (step_l.cov) begin
            we          = 1'b1;
            wa          = wl_r.p;
            wd          = {val_r, val_r, SUM_W'(val_r)};
            acc_sum_nxt = SUM_W'(val_r);
            acc_min_nxt = val_r;
            acc_max_nxt = val_r;
            up_p_nxt    = wl_r.p;
            if (wl_r.p == root_addr) begin
              state_nxt = ST_FIN;
            end else begin
              re_a      = 1'b1;
              ra        = {wl_r.p[ADDR_W-1:1], ~wl_r.p[0]};
              rv_a_nxt  = 1'b1;
              state_nxt = ST_UP;
            end
          end else if (step_l.go_l) begin
            wl_nxt = step_l.lch;
          end else begin
            wl_nxt = step_l.rch;
          end
        end else begin
          acc_sum_nxt = acc_sum_r + add_a + add_b;
          acc_min_nxt = rv_b_r ? smin(min1, b_min) : min1;
          acc_max_nxt = rv_b_r ? smax(max1, b_max) : max1;
          if (wl_act_r) begin
            if (step_l.cov) begin
              re_a       = 1'b1;
              ra         = wl_r.p;
              rv_a_nxt   = 1'b1;
              wl_act_nxt = 1'b0;
            end else if (step_l.go_l) begin
              wl_nxt = step_l.lch;
            end else if (step_l.go_r) begin
              wl_nxt = step_l.rch;
            end else if (!split_r) begin
              wl_nxt     = step_l.lch;
              wr_nxt     = step_l.rch;
              wr_act_nxt = 1'b1;
              split_nxt  = 1'b1;
            end else begin
              re_a     = 1'b1;
              ra       = step_l.rch.p;
              rv_a_nxt = 1'b1;
              wl_nxt   = step_l.lch;
            end
          end
          if (wr_act_r) begin
            if (step_r.cov) begin
              re_b       = 1'b1;
              rb         = wr_r.p;
              rv_b_nxt   = 1'b1;
              wr_act_nxt = 1'b0;
            end else if (step_r.go_l) begin
              wr_nxt = step_r.lch;
            end else if (step_r.go_r) begin
              wr_nxt = step_r.rch;
            end else begin
              re_b     = 1'b1;
              rb       = step_r.lch.p;
              rv_b_nxt = 1'b1;
              wr_nxt   = step_r.rch;
            end
          end
          if (!wl_act_r && !wr_act_r && !rv_a_r && !rv_b_r) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_UP: begin
        if (rv_a_r) begin
          acc_sum_nxt = acc_sum_r + a_sum;
          acc_min_nxt = smin(acc_min_r, a_min);
          acc_max_nxt = smax(acc_max_r, a_max);
          we          = 1'b1;
          wa          = par;
          wd          = {acc_max_nxt, acc_min_nxt, acc_sum_nxt};
          up_p_nxt    = par;
          if (par == root_addr) begin
            state_nxt = ST_FIN;
          end else begin
            re_a     = 1'b1;
            ra       = {par[ADDR_W-1:1], ~par[0]};
            rv_a_nxt = 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      kind_r       <= KIND_UPDATE;
      err_r        <= 1'b0;
      wl_act_r     <= 1'b0;
      wr_act_r     <= 1'b0;
      split_r      <= 1'b0;
      rv_a_r       <= 1'b0;
      rv_b_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      kind_r       <= kind_nxt;
      err_r        <= err_nxt;
      wl_act_r     <= wl_act_nxt;
      wr_act_r     <= wr_act_nxt;
      split_r      <= split_nxt;
      rv_a_r       <= rv_a_nxt;
      rv_b_r       <= rv_b_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    wl_r      <= wl_nxt;
    wr_r      <= wr_nxt;
    up_p_r    <= up_p_nxt;
    acc_sum_r <= acc_sum_nxt;
    acc_min_r <= acc_min_nxt;
    acc_max_r <= acc_max_nxt;
    val_r     <= val_nxt;
    if (out_load) begin
      if ((kind_r == KIND_QUERY) && !err_r) begin
        out_sum_r <= SUM_OUT_W'(acc_sum_r);
        out_min_r <= acc_min_r;
        out_max_r <= acc_max_r;
      end else begin
        out_sum_r <= '0;
        out_min_r <= '0;
        out_max_r <= '0;
      end
      out_err_r <= err_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_max_r, out_min_r, out_sum_r};
  assign out_tuser  = out_err_r;

endmodule

/* hw/rtl/rsmmt_checker.sv */
module rsmmt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rsmmt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import rsmmt_pkg::*;

  logic signed [VAL_W-1:0] o_min, o_max;
  assign o_min = $signed(out_tdata[SUM_OUT_W +: VAL_W]);
  assign o_max = $signed(out_tdata[SUM_OUT_W+VAL_W +: VAL_W]);

  // reset starts the clearing pass: no request taken, no result shown
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("request or result right after reset");

  // one request in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("rejected request with nonzero result");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> o_min <= o_max)
    else $error("range_min above range_max");

endmodule

bind range_sum_min_max_tree_top rsmmt_checker u_rsmmt_checker (.*);

/* sim/tb_range_sum_min_max_tree_top.sv */
`timescale 1ns / 1ps

module tb_range_sum_min_max_tree_top;
  import rsmmt_pkg::*;

  localparam int ELEMENTS   = ELEMENTS_DEF;
  localparam int CYCLE_CAP  = 1000000;
  localparam int IDLE_PCT   = 16;
  localparam int QUIET_FROM = 15000;
  localparam int QUIET_TO   = 30000;
  localparam int TAIL_WAIT  = 60;

  typedef struct {
    logic                     kind;
    logic [POS_FW-1:0]        position;
    logic [POS_FW-1:0]        last_position;
    logic signed [VAL_W-1:0]  value;
    bit                       drain;
  } tree_req_t;

  typedef struct {
    logic signed [SUM_OUT_W-1:0] rsum;
    logic signed [VAL_W-1:0]     rmin;
    logic signed [VAL_W-1:0]     rmax;
    logic                        err;
  } tree_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  logic signed [VAL_W-1:0] elem_val [1:ELEMENTS];
  tree_req_t               req_feed_q[$];
  tree_res_t               answer_q[$];
  tree_req_t               req_on_bus;
  tree_req_t               next_req;
  tree_res_t               want;
  bit                      send_now;
  int                      cycle_cnt = 0;
  int                      fail_cnt = 0;
  wire                     quiet = cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO;

  range_sum_min_max_tree_top #(.ELEMENTS(ELEMENTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies a request to the element array and returns its answer
  function automatic tree_res_t apply_request(tree_req_t r);
    tree_res_t               res;
    longint                  acc;
    int                      lo;
    int                      hi;
    logic signed [VAL_W-1:0] mn;
    logic signed [VAL_W-1:0] mx;
    res = '{default: '0};
    if (r.kind == KIND_UPDATE) begin
      if (r.position == 0 || int'(r.position) > ELEMENTS) begin
        res.err = 1'b1;
      end else begin
        elem_val[r.position] = r.value;
      end
    end else begin
      lo = (r.position < 1) ? 1 : int'(r.position);
      hi = (int'(r.last_position) > ELEMENTS) ? ELEMENTS : int'(r.last_position);
      if (r.position > r.last_position || lo > hi) begin
        res.err = 1'b1;
      end else begin
        acc = 0;
        mn = elem_val[lo];
        mx = elem_val[lo];
        for (int i = lo; i <= hi; i++) begin
          acc += elem_val[i];
          if (elem_val[i] < mn) mn = elem_val[i];
          if (elem_val[i] > mx) mx = elem_val[i];
        end
        res.rsum = acc[SUM_OUT_W-1:0];
        res.rmin = mn;
        res.rmax = mx;
      end
    end
    return res;
  endfunction

  task automatic add_req(logic kind, int pos, int last, int val, bit drain = 1'b0);
    tree_req_t r;
    r.kind = kind;
    r.position = pos[POS_FW-1:0];
    r.last_position = last[POS_FW-1:0];
    r.value = val[VAL_W-1:0];
    r.drain = drain;
    req_feed_q.push_back(r);
  endtask

  task automatic add_rand_query();
    int lo;
    int span;
    int hi;
    lo = $urandom_range(ELEMENTS, 1);
    span = ($urandom_range(3) == 0) ? $urandom_range(ELEMENTS - 1) : $urandom_range(15);
    hi = (lo + span > ELEMENTS) ? ELEMENTS : lo + span;
    add_req(KIND_QUERY, lo, hi, $urandom_range(65535));
  endtask

  function automatic int rand_value();
    case ($urandom_range(7))
      0:       return -32768;
      1:       return 32767;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic report_mismatch(string field, longint exp_v, longint got_v);
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_v, got_v);
    fail_cnt++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        answer_q.push_back(apply_request(req_on_bus));
      end
      send_now = 1'b0;
      if (req_feed_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT) &&
          !(req_feed_q[0].drain && answer_q.size() != 0)) begin
        next_req = req_feed_q.pop_front();
        req_on_bus = next_req;
        in_tdata <= {2'b00, next_req.value, next_req.last_position, next_req.position};
        in_tuser <= next_req.kind;
        send_now = 1'b1;
      end
      in_tvalid <= send_now;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h/%b", $time, out_tdata,
                   out_tuser);
          fail_cnt++;
        end else begin
          want = answer_q.pop_front();
          if ($signed(out_tdata[25:0]) !== want.rsum)
            report_mismatch("range_sum", longint'(want.rsum),
                            longint'($signed(out_tdata[25:0])));
          if ($signed(out_tdata[41:26]) !== want.rmin)
            report_mismatch("range_min", longint'(want.rmin),
                            longint'($signed(out_tdata[41:26])));
          if ($signed(out_tdata[57:42]) !== want.rmax)
            report_mismatch("range_max", longint'(want.rmax),
                            longint'($signed(out_tdata[57:42])));
          if (out_tuser !== want.err)
            report_mismatch("error", longint'(want.err), longint'(out_tuser));
        end
      end
      out_tready <= quiet || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int i = 1; i <= ELEMENTS; i++) elem_val[i] = '0;

    // directed: cleared store, bad positions, clamping, empty and reversed ranges
    add_req(KIND_QUERY, 0, 2047, 0);
    add_req(KIND_UPDATE, 0, 5, 123);
    add_req(KIND_UPDATE, ELEMENTS + 1, 0, 7);
    add_req(KIND_UPDATE, 2047, 2047, -1);
    add_req(KIND_UPDATE, 1, 2047, -32768);
    add_req(KIND_UPDATE, ELEMENTS, 0, 32767);
    add_req(KIND_UPDATE, 512, 0, 1);
    add_req(KIND_UPDATE, 513, 0, -1);
    add_req(KIND_QUERY, 1, ELEMENTS, -1);
    add_req(KIND_QUERY, 0, 2047, 32767);
    add_req(KIND_QUERY, 0, 0, 0);
    add_req(KIND_QUERY, ELEMENTS + 1, 2047, 0);
    add_req(KIND_QUERY, 5, 4, 0);
    add_req(KIND_QUERY, 2047, 0, 0);
    add_req(KIND_QUERY, 1, 1, 0);
    add_req(KIND_QUERY, ELEMENTS, ELEMENTS, 0);
    add_req(KIND_QUERY, 512, 513, 0);
    add_req(KIND_QUERY, 0, 1, 0);
    add_req(KIND_QUERY, 2, ELEMENTS - 1, 0);
    add_req(KIND_UPDATE, 1, 0, 0);
    add_req(KIND_QUERY, 1, 2, 0);
    add_req(KIND_QUERY, ELEMENTS, 2047, 0);

    // sweep every element to the negative extreme, probing ranges on the way
    for (int p = 1; p <= ELEMENTS; p++) begin
      add_req(KIND_UPDATE, p, $urandom_range(2047), -32768);
      if (p % 8 == 0) add_rand_query();
    end
    add_req(KIND_QUERY, 1, ELEMENTS, 0);

    // sender holds off until every result is back
    add_req(KIND_QUERY, 0, 2047, 0, 1'b1);

    for (int n = 0; n < 520; n++) begin
      case ($urandom_range(19))
        0, 1: add_req(1'($urandom_range(1)), $urandom_range(2047), $urandom_range(2047),
                      $urandom_range(65535));
        2, 3, 4, 5, 6, 7, 8, 9, 10:
          add_req(KIND_UPDATE, $urandom_range(ELEMENTS, 1), $urandom_range(2047),
                  rand_value());
        default: add_rand_query();
      endcase
    end
    add_req(KIND_QUERY, 1, ELEMENTS, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (req_feed_q.size() != 0 || in_tvalid) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
